// File: rtl/trc_hdr_pkg.sv
// Shared constants and types for the trace header parser.
package trc_hdr_pkg;

  localparam int TRACE_DIGITS = 32;
  localparam int SPAN_DIGITS  = 16;
  localparam int POS_W        = 6;
  localparam int ID_W         = 64;

  localparam logic [POS_W-1:0] DASH_ONE_POS = POS_W'(TRACE_DIGITS);
  localparam logic [POS_W-1:0] HALF_POS     = POS_W'(TRACE_DIGITS / 2);
  localparam logic [POS_W-1:0] MIN_LEN      = POS_W'(TRACE_DIGITS + 1 + SPAN_DIGITS);
  localparam logic [POS_W-1:0] FLAG_POS     = POS_W'(TRACE_DIGITS + 2 + SPAN_DIGITS);
  localparam logic [POS_W-1:0] FULL_LEN     = POS_W'(TRACE_DIGITS + 3 + SPAN_DIGITS);
  localparam logic [POS_W-1:0] POS_SAT      = POS_W'(TRACE_DIGITS + 4 + SPAN_DIGITS);

  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_F    = 8'h66;

  typedef enum logic [2:0] {
    REASON_OK   = 3'd0,
    REASON_LEN  = 3'd1,
    REASON_HEX  = 3'd2,
    REASON_ZERO = 3'd3,
    REASON_FLAG = 3'd4
  } reason_e;

endpackage

// File: rtl/trace_header_parser.sv
// Trace header parser top level: byte-wise form check and id decode.
//
// Input channel: one header character per word on header_byte_i, with
// last_byte_i marking the final character. A word is taken at a rising edge
// with in_valid_i high and in_stall_o low.
// Output channel: one result word per header, presented on out_valid_o with
// accepted_o, reason_o, the decoded ids and the sampling flags; the receiver
// holds it with out_stall_i.
// Throughput: one character per cycle, back to back, while in_stall_o is low.
// Each character needs only position compares, a hex check and a nibble shift into the id registers or a flag update.
// Latency: the result appears in the cycle after the final character is
// taken, from the single output register.
// Reset: clears the position counter, id registers and check flags; no
// result is pending after reset. All parse state also clears after every
// final character.
// Stall: in_stall_o rises only while a result waits and out_stall_i is high;
// a character that arrives while the output register is free is taken even
// if the receiver stalls.
module trace_header_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    header_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [2:0]                    reason_o,
  output logic [trc_hdr_pkg::ID_W-1:0]  trace_high_o,
  output logic [trc_hdr_pkg::ID_W-1:0]  trace_low_o,
  output logic [trc_hdr_pkg::ID_W-1:0]  parent_span_o,
  output logic                          sampled_o,
  output logic                          decision_present_o
);

  logic [trc_hdr_pkg::POS_W-1:0] position_q, position_d;
  logic [trc_hdr_pkg::ID_W-1:0]  trace_hi_q, trace_hi_d;
  logic [trc_hdr_pkg::ID_W-1:0]  trace_lo_q, trace_lo_d;
  logic [trc_hdr_pkg::ID_W-1:0]  span_q, span_d;
  logic                          dash_one_q, dash_one_d;
  logic                          dash_two_q, dash_two_d;
  logic                          hex_bad_q, hex_bad_d;
  logic                          trace_nz_q, trace_nz_d;
  logic                          span_nz_q, span_nz_d;
  logic [7:0]                    flag_q, flag_d;

  logic                          out_valid_q;
  logic                          accepted_q;
  trc_hdr_pkg::reason_e          reason_q;
  logic [trc_hdr_pkg::ID_W-1:0]  res_hi_q, res_lo_q, res_span_q;
  logic                          sampled_q, decided_q;

  logic                          in_acc;
  logic                          out_free;
  logic                          is_hex;
  logic [3:0]                    nibble;
  trc_hdr_pkg::reason_e          reason_d;
  logic                          sampled_d, decided_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_acc     = in_valid_i && out_free;

  always_comb begin
    is_hex = 1'b0;
    nibble = 4'd0;
    if (header_byte_i inside {[trc_hdr_pkg::CH_ZERO:trc_hdr_pkg::CH_NINE]}) begin
      is_hex = 1'b1;
      nibble = 4'(header_byte_i - trc_hdr_pkg::CH_ZERO);
    end else if (header_byte_i inside {[trc_hdr_pkg::CH_A:trc_hdr_pkg::CH_F]}) begin
      is_hex = 1'b1;
      nibble = 4'(header_byte_i - trc_hdr_pkg::CH_A + 8'd10);
    end
  end

  always_comb begin
    trace_hi_d = trace_hi_q;
    trace_lo_d = trace_lo_q;
    span_d     = span_q;
    dash_one_d = dash_one_q;
    dash_two_d = dash_two_q;
    hex_bad_d  = hex_bad_q;
    trace_nz_d = trace_nz_q;
    span_nz_d  = span_nz_q;
    flag_d     = flag_q;
    if (position_q < trc_hdr_pkg::DASH_ONE_POS) begin
      hex_bad_d  = hex_bad_q || !is_hex;
      trace_nz_d = trace_nz_q || (header_byte_i != trc_hdr_pkg::CH_ZERO);
      if (position_q < trc_hdr_pkg::HALF_POS) begin
        trace_hi_d = {trace_hi_q[trc_hdr_pkg::ID_W-5:0], nibble};
      end else begin
        trace_lo_d = {trace_lo_q[trc_hdr_pkg::ID_W-5:0], nibble};
      end
    end else if (position_q == trc_hdr_pkg::DASH_ONE_POS) begin
      dash_one_d = (header_byte_i == trc_hdr_pkg::CH_DASH);
    end else if (position_q < trc_hdr_pkg::MIN_LEN) begin
      hex_bad_d = hex_bad_q || !is_hex;
      span_nz_d = span_nz_q || (header_byte_i != trc_hdr_pkg::CH_ZERO);
      span_d    = {span_q[trc_hdr_pkg::ID_W-5:0], nibble};
    end else if (position_q == trc_hdr_pkg::MIN_LEN) begin
      dash_two_d = (header_byte_i == trc_hdr_pkg::CH_DASH);
    end else if (position_q == trc_hdr_pkg::FLAG_POS) begin
      flag_d = header_byte_i;
    end
    position_d = (position_q < trc_hdr_pkg::POS_SAT) ? position_q + 1'b1
                                                      : trc_hdr_pkg::POS_SAT;
  end

  always_comb begin
    reason_d  = trc_hdr_pkg::REASON_OK;
    sampled_d = 1'b0;
    decided_d = 1'b0;
    if (position_d < trc_hdr_pkg::MIN_LEN || !dash_one_d) begin
      reason_d = trc_hdr_pkg::REASON_LEN;
    end else if (hex_bad_d) begin
      reason_d = trc_hdr_pkg::REASON_HEX;
    end else if (!trace_nz_d || !span_nz_d) begin
      reason_d = trc_hdr_pkg::REASON_ZERO;
    end else if (position_d > trc_hdr_pkg::MIN_LEN) begin
      if (position_d != trc_hdr_pkg::FULL_LEN || !dash_two_d) begin
        reason_d = trc_hdr_pkg::REASON_LEN;
      end else if (flag_d == trc_hdr_pkg::CH_ONE) begin
        sampled_d = 1'b1;
        decided_d = 1'b1;
      end else if (flag_d == trc_hdr_pkg::CH_ZERO) begin
        decided_d = 1'b1;
      end else begin
        reason_d = trc_hdr_pkg::REASON_FLAG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      trace_hi_q <= '0;
      trace_lo_q <= '0;
      span_q     <= '0;
      dash_one_q <= 1'b0;
      dash_two_q <= 1'b0;
      hex_bad_q  <= 1'b0;
      trace_nz_q <= 1'b0;
      span_nz_q  <= 1'b0;
      flag_q     <= '0;
    end else if (in_acc) begin
      if (last_byte_i) begin
        position_q <= '0;
        trace_hi_q <= '0;
        trace_lo_q <= '0;
        span_q     <= '0;
        dash_one_q <= 1'b0;
        dash_two_q <= 1'b0;
        hex_bad_q  <= 1'b0;
        trace_nz_q <= 1'b0;
        span_nz_q  <= 1'b0;
        flag_q     <= '0;
      end else begin
        position_q <= position_d;
        trace_hi_q <= trace_hi_d;
        trace_lo_q <= trace_lo_d;
        span_q     <= span_d;
        dash_one_q <= dash_one_d;
        dash_two_q <= dash_two_d;
        hex_bad_q  <= hex_bad_d;
        trace_nz_q <= trace_nz_d;
        span_nz_q  <= span_nz_d;
        flag_q     <= flag_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_acc && last_byte_i;
    end
  end

  // load the result word; rejected headers report zero ids and flags
  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      if (reason_d == trc_hdr_pkg::REASON_OK) begin
        accepted_q <= 1'b1;
        reason_q   <= trc_hdr_pkg::REASON_OK;
        res_hi_q   <= trace_hi_d;
        res_lo_q   <= trace_lo_d;
        res_span_q <= span_d;
        sampled_q  <= sampled_d;
        decided_q  <= decided_d;
      end else begin
        accepted_q <= 1'b0;
        reason_q   <= reason_d;
        res_hi_q   <= '0;
        res_lo_q   <= '0;
        res_span_q <= '0;
        sampled_q  <= 1'b0;
        decided_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = accepted_q;
  assign reason_o           = reason_q;
  assign trace_high_o       = res_hi_q;
  assign trace_low_o        = res_lo_q;
  assign parent_span_o      = res_span_q;
  assign sampled_o          = sampled_q;
  assign decision_present_o = decided_q;

endmodule

// File: rtl/trc_hdr_checker.sv
// Port-level assertions for the trace header parser, bound to the top level.
module trc_hdr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [7:0]                    header_byte_i,
  input logic                          last_byte_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          accepted_o,
  input logic [2:0]                    reason_o,
  input logic [trc_hdr_pkg::ID_W-1:0]  trace_high_o,
  input logic [trc_hdr_pkg::ID_W-1:0]  trace_low_o,
  input logic [trc_hdr_pkg::ID_W-1:0]  parent_span_o,
  input logic                          sampled_o,
  input logic                          decision_present_o
);

  logic unused_byte;
  assign unused_byte = ^header_byte_i;

  // a final word always yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> out_valid_o)
    else $error("final word gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reason_o)
      && $stable(accepted_o) && $stable(trace_high_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (reason_o == 3'(trc_hdr_pkg::REASON_OK))))
    else $error("accept and reason disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> trace_high_o == '0 && trace_low_o == '0
      && parent_span_o == '0 && !sampled_o && !decision_present_o)
    else $error("rejected header carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sampled_o |-> decision_present_o && accepted_o)
    else $error("sampled without decision");

endmodule

bind trace_header_parser trc_hdr_checker u_trc_hdr_checker (.*);

// File: sim/tb_trace_header_parser.sv
// Self-checking testbench for trace_header_parser: directed and random headers.
`timescale 1ns / 100ps

module tb_trace_header_parser;

  localparam int WATCH_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int NO_FLAG      = -1;
  localparam int PHASE_WORDS  = 90;
  localparam int PHASE_HDRS   = 2;
  localparam int BURST_HDRS   = 20;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [7:0] hdr_q_t[$];

  typedef struct {
    logic                           accepted;
    logic [2:0]                     reason;
    logic [trc_hdr_pkg::ID_W-1:0]   trace_high;
    logic [trc_hdr_pkg::ID_W-1:0]   trace_low;
    logic [trc_hdr_pkg::ID_W-1:0]   parent_span;
    logic                           sampled;
    logic                           decision;
  } hdr_result_t;

  class hdr_scoreboard;
    bit [trc_hdr_pkg::POS_W-1:0] pos;
    bit [trc_hdr_pkg::ID_W-1:0]  trace_hi;
    bit [trc_hdr_pkg::ID_W-1:0]  trace_lo;
    bit [trc_hdr_pkg::ID_W-1:0]  span;
    bit                          dash_one;
    bit                          dash_two;
    bit                          hex_bad;
    bit                          trace_nz;
    bit                          span_nz;
    bit [7:0]                    flag_ch;
    hdr_result_t                 expected_q[$];
    int                          errors;
    int                          words;
    int                          headers;
    int                          results;
    int                          outcome_cnt[5];

    function bit is_hex(bit [7:0] ch);
      return (ch >= trc_hdr_pkg::CH_ZERO && ch <= trc_hdr_pkg::CH_NINE) ||
             (ch >= trc_hdr_pkg::CH_A && ch <= trc_hdr_pkg::CH_F);
    endfunction

    function bit [3:0] nibble(bit [7:0] ch);
      if (ch >= trc_hdr_pkg::CH_ZERO && ch <= trc_hdr_pkg::CH_NINE)
        return 4'(ch - trc_hdr_pkg::CH_ZERO);
      if (ch >= trc_hdr_pkg::CH_A && ch <= trc_hdr_pkg::CH_F)
        return 4'(ch - trc_hdr_pkg::CH_A + 8'd10);
      return 4'd0;
    endfunction

    function void clear();
      pos      = '0;
      trace_hi = '0;
      trace_lo = '0;
      span     = '0;
      dash_one = 1'b0;
      dash_two = 1'b0;
      hex_bad  = 1'b0;
      trace_nz = 1'b0;
      span_nz  = 1'b0;
      flag_ch  = '0;
    endfunction

    function void note_word(logic [7:0] ch, logic last);
      trc_hdr_pkg::reason_e why;
      bit                   samp;
      bit                   dec;
      hdr_result_t          exp_res;
      words++;
      if (pos < trc_hdr_pkg::TRACE_DIGITS) begin
        if (!is_hex(ch)) hex_bad = 1'b1;
        if (ch != trc_hdr_pkg::CH_ZERO) trace_nz = 1'b1;
        if (pos < trc_hdr_pkg::HALF_POS)
          trace_hi = {trace_hi[trc_hdr_pkg::ID_W-5:0], nibble(ch)};
        else trace_lo = {trace_lo[trc_hdr_pkg::ID_W-5:0], nibble(ch)};
      end else if (pos == trc_hdr_pkg::DASH_ONE_POS) begin
        dash_one = (ch == trc_hdr_pkg::CH_DASH);
      end else if (pos < trc_hdr_pkg::MIN_LEN) begin
        if (!is_hex(ch)) hex_bad = 1'b1;
        if (ch != trc_hdr_pkg::CH_ZERO) span_nz = 1'b1;
        span = {span[trc_hdr_pkg::ID_W-5:0], nibble(ch)};
      end else if (pos == trc_hdr_pkg::MIN_LEN) begin
        dash_two = (ch == trc_hdr_pkg::CH_DASH);
      end else if (pos == trc_hdr_pkg::FLAG_POS) begin
        flag_ch = ch;
      end
      if (pos < trc_hdr_pkg::POS_SAT) pos++;
      if (!last) return;

      why  = trc_hdr_pkg::REASON_OK;
      samp = 1'b0;
      dec  = 1'b0;
      if (pos < trc_hdr_pkg::MIN_LEN || !dash_one) why = trc_hdr_pkg::REASON_LEN;
      else if (hex_bad) why = trc_hdr_pkg::REASON_HEX;
      else if (!trace_nz || !span_nz) why = trc_hdr_pkg::REASON_ZERO;
      else if (pos > trc_hdr_pkg::MIN_LEN) begin
        if (pos != trc_hdr_pkg::FULL_LEN || !dash_two) why = trc_hdr_pkg::REASON_LEN;
        else if (flag_ch == trc_hdr_pkg::CH_ONE) begin
          samp = 1'b1;
          dec  = 1'b1;
        end else if (flag_ch == trc_hdr_pkg::CH_ZERO) begin
          dec = 1'b1;
        end else begin
          why = trc_hdr_pkg::REASON_FLAG;
        end
      end

      exp_res.accepted    = (why == trc_hdr_pkg::REASON_OK);
      exp_res.reason      = why;
      exp_res.trace_high  = (why == trc_hdr_pkg::REASON_OK) ? trace_hi : '0;
      exp_res.trace_low   = (why == trc_hdr_pkg::REASON_OK) ? trace_lo : '0;
      exp_res.parent_span = (why == trc_hdr_pkg::REASON_OK) ? span : '0;
      exp_res.sampled     = samp;
      exp_res.decision    = dec;
      expected_q.push_back(exp_res);
      outcome_cnt[why]++;
      headers++;
      clear();
    endfunction

    function void check_field(string name, logic [trc_hdr_pkg::ID_W-1:0] want,
                              logic [trc_hdr_pkg::ID_W-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %h, actual %h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result word with no header pending");
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      results++;
      check_field("accepted", exp_res.accepted, got.accepted);
      check_field("reason", exp_res.reason, got.reason);
      check_field("trace_high", exp_res.trace_high, got.trace_high);
      check_field("trace_low", exp_res.trace_low, got.trace_low);
      check_field("parent_span", exp_res.parent_span, got.parent_span);
      check_field("sampled", exp_res.sampled, got.sampled);
      check_field("decision_present", exp_res.decision, got.decision);
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [7:0]                   header_byte_i = '0;
  logic                         last_byte_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         accepted_o;
  logic [2:0]                   reason_o;
  logic [trc_hdr_pkg::ID_W-1:0] trace_high_o;
  logic [trc_hdr_pkg::ID_W-1:0] trace_low_o;
  logic [trc_hdr_pkg::ID_W-1:0] parent_span_o;
  logic                         sampled_o;
  logic                         decision_present_o;

  hdr_scoreboard sb = new;
  int send_idle_pct = 34;
  int recv_idle_pct = 72;
  int hold_seq = 0;

  trace_header_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .header_byte_i      (header_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .accepted_o         (accepted_o),
    .reason_o           (reason_o),
    .trace_high_o       (trace_high_o),
    .trace_low_o        (trace_low_o),
    .parent_span_o      (parent_span_o),
    .sampled_o          (sampled_o),
    .decision_present_o (decision_present_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(15);
    return (v < 10) ? 8'(trc_hdr_pkg::CH_ZERO + v) : 8'(trc_hdr_pkg::CH_A + v - 10);
  endfunction

  function automatic void well_formed(ref hdr_q_t hdr, input int flag);
    hdr.delete();
    repeat (trc_hdr_pkg::TRACE_DIGITS) hdr.push_back(rand_hex());
    hdr.push_back(trc_hdr_pkg::CH_DASH);
    repeat (trc_hdr_pkg::SPAN_DIGITS) hdr.push_back(rand_hex());
    if (flag != NO_FLAG) begin
      hdr.push_back(trc_hdr_pkg::CH_DASH);
      hdr.push_back(flag[7:0]);
    end
  endfunction

  function automatic void fill_ids(ref hdr_q_t hdr, input logic [7:0] ch,
                                   input bit do_trace, input bit do_span);
    for (int i = 0; i < trc_hdr_pkg::TRACE_DIGITS; i++) if (do_trace) hdr[i] = ch;
    for (int i = 0; i < trc_hdr_pkg::SPAN_DIGITS; i++)
      if (do_span) hdr[trc_hdr_pkg::TRACE_DIGITS + 1 + i] = ch;
  endfunction

  function automatic int rand_flag();
    case ($urandom_range(2))
      0:       return NO_FLAG;
      1:       return trc_hdr_pkg::CH_ZERO;
      default: return trc_hdr_pkg::CH_ONE;
    endcase
  endfunction

  task automatic send_word(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    header_byte_i <= ch;
    last_byte_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(ch, last);
  endtask

  task automatic send_header(input hdr_q_t hdr);
    foreach (hdr[i]) send_word(hdr[i], i == hdr.size() - 1);
  endtask

  // Receiver: check accepted results, then pick the stall for the next cycle.
  initial begin
    int          hold_left;
    int          seen_seq;
    hdr_result_t got;
    hold_left = 0;
    seen_seq  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.accepted    = accepted_o;
        got.reason      = reason_o;
        got.trace_high  = trace_high_o;
        got.trace_low   = trace_low_o;
        got.parent_span = parent_span_o;
        got.sampled     = sampled_o;
        got.decision    = decision_present_o;
        sb.check_result(got);
      end
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCH_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", quiet);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    hdr_q_t hdr;
    int     phase_words;
    int     phase_hdrs;
    int     pick;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    well_formed(hdr, NO_FLAG);
    send_header(hdr);
    well_formed(hdr, 8'h32);
    send_header(hdr);
    hdr = '{8'h00};
    send_header(hdr);
    well_formed(hdr, trc_hdr_pkg::CH_ONE);
    hdr[trc_hdr_pkg::DASH_ONE_POS] = 8'h5f;
    send_header(hdr);
    well_formed(hdr, trc_hdr_pkg::CH_ONE);
    repeat (13) hdr.push_back(rand_hex());
    send_header(hdr);
    well_formed(hdr, NO_FLAG);
    hdr[3] = 8'h47;
    hdr = hdr[0:39];
    send_header(hdr);
    well_formed(hdr, trc_hdr_pkg::CH_ONE);
    fill_ids(hdr, trc_hdr_pkg::CH_ZERO, 1'b1, 1'b0);
    hdr[33] = 8'h78;
    send_header(hdr);
    well_formed(hdr, 8'h7a);
    hdr[trc_hdr_pkg::MIN_LEN] = 8'h5f;
    send_header(hdr);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 72 : 0;
      recv_idle_pct <= (phase == 0) ? 72 : (phase == 1) ? 34 : 0;
      if (phase == 2) begin
        hold_seq <= hold_seq + 1;
        repeat (BURST_HDRS) begin
          hdr.delete();
          repeat ($urandom_range(1, 3)) hdr.push_back(8'($urandom_range(255)));
          send_header(hdr);
        end
      end
      phase_words = 0;
      phase_hdrs  = 0;
      while (phase_words < PHASE_WORDS || phase_hdrs < PHASE_HDRS) begin
        pick = $urandom_range(99);
        well_formed(hdr, rand_flag());
        if (pick >= 60 && pick < 75) begin
          hdr[$urandom_range(hdr.size() - 1)] = 8'($urandom_range(255));
        end else if (pick >= 75 && pick < 85) begin
          hdr.delete();
          repeat ($urandom_range(1, 64)) hdr.push_back(8'($urandom_range(255)));
        end else if (pick >= 85 && pick < 93) begin
          if ($urandom_range(1)) hdr = hdr[0:$urandom_range(hdr.size() - 2)];
          else repeat ($urandom_range(1, 14)) hdr.push_back(8'($urandom_range(255)));
        end else if (pick >= 93) begin
          case ($urandom_range(2))
            0:       fill_ids(hdr, trc_hdr_pkg::CH_ZERO, 1'b1, 1'b0);
            1:       fill_ids(hdr, trc_hdr_pkg::CH_ZERO, 1'b0, 1'b1);
            default: well_formed(hdr, $urandom_range(255));
          endcase
        end
        send_header(hdr);
        phase_words += hdr.size();
        phase_hdrs++;
      end
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d header bytes in %0d headers, %0d results compared.",
             sb.words, sb.headers, sb.results);
    $display("Outcomes: %0d accepted, %0d length/dash, %0d non-hex, %0d zero id, %0d bad flag.",
             sb.outcome_cnt[trc_hdr_pkg::REASON_OK], sb.outcome_cnt[trc_hdr_pkg::REASON_LEN],
             sb.outcome_cnt[trc_hdr_pkg::REASON_HEX], sb.outcome_cnt[trc_hdr_pkg::REASON_ZERO],
             sb.outcome_cnt[trc_hdr_pkg::REASON_FLAG]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/trc_hdr_pkg.sv
rtl/trace_header_parser.sv
rtl/trc_hdr_checker.sv
sim/tb_trace_header_parser.sv
